/* sv/bpfa_pkg.sv */
// bpfa_pkg: shared types and constants of the bitmap page frame allocator
// no dependencies; used by every other file of the block except bpfa_bitmap_ram
package bpfa_pkg;

  localparam int FRAME_SHIFT = 12;    // 4096-byte frames
  localparam int ADDR_FRAMES = 4096;  // frames a 24-bit address reaches
  localparam int FRAME_W     = 12;    // frame index width
  localparam int CNT_W       = 13;    // frame counts, limit, config register
  localparam int ADDR_W      = 24;    // byte address width

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_MARK  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NONE_FREE = 2'd1,
    STAT_UNCHANGED = 2'd2,
    STAT_RANGE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_RMW,
    ST_DONE
  } ctrl_state_e;

endpackage

/* sv/bpfa_bitmap_ram.sv */
// bpfa_bitmap_ram: used-bit memory, one scan word per row
// one write port, one read port with registered read data; no package use
module bpfa_bitmap_ram #(
  parameter int WORDS  = 64,
  parameter int WORD_W = 64,
  parameter int AW     = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bpfa_scan_unit.sv */
// bpfa_scan_unit: find-first-clear over one bitmap word, bits past the limit masked
// uses bpfa_pkg for the count width
module bpfa_scan_unit #(
  parameter int WORD_W = 64,
  parameter int PW     = 6
) (
  input  logic [WORD_W-1:0]           word_i,
  input  logic [bpfa_pkg::CNT_W-1:0]  left_i,   // frames still in range from bit 0
  output logic                        found_o,
  output logic [PW-1:0]               pos_o
);

  logic [WORD_W-1:0] avail;

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      avail[i] = ~word_i[i] && (bpfa_pkg::CNT_W'(i) < left_i);
    end
  end

  // lowest clear bit wins
  always_comb begin
    pos_o = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pos_o = PW'(i);
      end
    end
  end

  assign found_o = |avail;

endmodule

/* sv/bitmap_page_frame_allocator.sv */
// bitmap_page_frame_allocator: first-fit page frame allocator over a used-bit bitmap
// allocate scans k words, k from 1 to ceil(limit/SCAN_WORD_BITS) (64 at default), and
//   writes the word with the hit; free and mark read and write one word, none out of range;
//   one item at a time: the next is taken once the result is in the output register
// reset: a clearing pass writes all ceil(min(MAX_PAGES, 4096)/SCAN_WORD_BITS) words (64 at
//   default) of the bitmap with frame 0 reserved; no item is taken meanwhile
module bitmap_page_frame_allocator #(
  parameter int MAX_PAGES      = 4096,
  parameter int SCAN_WORD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [bpfa_pkg::CNT_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]   frame_address_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpfa_pkg::ADDR_W-1:0]   result_address_o,
  output logic [1:0]                    status_o,
  output logic [bpfa_pkg::CNT_W-1:0]    free_pages_o,
  output logic [bpfa_pkg::CNT_W-1:0]    used_pages_o
);

  // frames actually reachable: the bitmap never holds more than an address reaches
  localparam int NFRAMES = (MAX_PAGES < bpfa_pkg::ADDR_FRAMES) ? MAX_PAGES
                                                                : bpfa_pkg::ADDR_FRAMES;
  localparam int WORD_W  = SCAN_WORD_BITS;
  localparam int WORDS   = (NFRAMES + WORD_W - 1) / WORD_W;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW      = (WORD_W > 1) ? $clog2(WORD_W) : 1;
  // frame / WORD_W as a reciprocal multiply, exact for every 12-bit frame index
  localparam int DIV_L   = $clog2(WORD_W);
  localparam int DIV_SH  = bpfa_pkg::FRAME_W + DIV_L;
  localparam int DIV_M   = ((1 << DIV_SH) + WORD_W - 1) / WORD_W;
  localparam int PROD_W  = bpfa_pkg::FRAME_W + bpfa_pkg::CNT_W + 1;

  localparam logic [bpfa_pkg::CNT_W-1:0] NFRAMES_C = bpfa_pkg::CNT_W'(NFRAMES);
  localparam logic [bpfa_pkg::CNT_W-1:0] WORD_W_C  = bpfa_pkg::CNT_W'(WORD_W);
  localparam logic [AW-1:0]              LAST_WORD = AW'(WORDS - 1);

  // state
  bpfa_pkg::ctrl_state_e state_q, state_d;

  logic [bpfa_pkg::CNT_W-1:0]  total_q;
  logic [bpfa_pkg::CNT_W-1:0]  used_q, used_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic [AW-1:0]               wa_q, wa_d;        // word being worked on
  logic [bpfa_pkg::CNT_W-1:0]  base_q, base_d;    // first frame of that word while scanning
  logic [1:0]                  act_q, act_d;
  logic [bpfa_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic [bpfa_pkg::ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [1:0]                  res_stat_q, res_stat_d;

  logic                        out_valid_q;
  logic [bpfa_pkg::ADDR_W-1:0] out_addr_q;
  logic [1:0]                  out_stat_q;
  logic [bpfa_pkg::CNT_W-1:0]  out_free_q, out_used_q;

  // bitmap ports
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  // datapath
  logic [bpfa_pkg::CNT_W-1:0]  lim;
  logic [bpfa_pkg::CNT_W-1:0]  left;
  logic [bpfa_pkg::CNT_W:0]    base_next;
  logic                        scan_found;
  logic [PW-1:0]               scan_pos;
  logic [bpfa_pkg::CNT_W-1:0]  hit_frame;
  logic [PROD_W-1:0]           div_prod;
  logic [AW-1:0]               div_q;
  logic [bpfa_pkg::CNT_W-1:0]  word_first;
  logic [bpfa_pkg::CNT_W-1:0]  rem_full;
  logic [PW-1:0]               rem;
  logic                        want;
  logic                        out_free_slot;
  logic                        out_load;
  logic [bpfa_pkg::CNT_W-1:0]  free_cnt;

  // effective limit: the register clipped to the frames the bitmap holds
  assign lim = (total_q > NFRAMES_C) ? NFRAMES_C : total_q;

  // scan unit inputs: frames of the current word still below the limit
  assign left      = (lim > base_q) ? (lim - base_q) : '0;
  assign base_next = {1'b0, base_q} + {1'b0, WORD_W_C};
  assign hit_frame = base_q + bpfa_pkg::CNT_W'(scan_pos);

  bpfa_scan_unit #(
    .WORD_W (WORD_W),
    .PW     (PW)
  ) u_scan (
    .word_i  (mem_rdata),
    .left_i  (left),
    .found_o (scan_found),
    .pos_o   (scan_pos)
  );

  // word index of the requested frame, then the bit within the word
  assign div_prod   = PROD_W'(frame_q) * PROD_W'(DIV_M);
  assign div_q      = AW'(div_prod >> DIV_SH);
  assign word_first = bpfa_pkg::CNT_W'(wa_q) * WORD_W_C;
  assign rem_full   = bpfa_pkg::CNT_W'(frame_q) - word_first;
  assign rem        = rem_full[PW-1:0];
  assign want       = (act_q == bpfa_pkg::ACT_MARK);

  assign out_free_slot = !out_valid_q || !out_stall_i;
  assign free_cnt      = (lim > used_q) ? (lim - used_q) : '0;

  bpfa_bitmap_ram #(
    .WORDS  (WORDS),
    .WORD_W (WORD_W),
    .AW     (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    clr_d      = clr_q;
    wa_d       = wa_q;
    base_d     = base_q;
    act_d      = act_q;
    frame_d    = frame_q;
    res_addr_d = res_addr_q;
    res_stat_d = res_stat_q;
    mem_we     = 1'b0;
    mem_waddr  = wa_q;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    out_load   = 1'b0;
    in_stall_o = 1'b1;

    unique case (state_q)
      bpfa_pkg::ST_CLEAR: begin
        // sweep the bitmap once, frame 0 comes up reserved
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == '0) begin
          mem_wdata[0] = 1'b1;
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_WORD) begin
          state_d = bpfa_pkg::ST_IDLE;
        end
      end

      bpfa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          act_d      = action_i;
          frame_d    = frame_address_i[bpfa_pkg::ADDR_W-1:bpfa_pkg::FRAME_SHIFT];
          res_addr_d = '0;
          unique case (action_i)
            bpfa_pkg::ACT_ALLOC: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              wa_d      = '0;
              base_d    = '0;
              state_d   = bpfa_pkg::ST_SCAN;
            end
            bpfa_pkg::ACT_FREE,
            bpfa_pkg::ACT_MARK: begin
              state_d = bpfa_pkg::ST_DIV;
            end
            default: begin
              res_stat_d = bpfa_pkg::STAT_UNCHANGED;
              state_d    = bpfa_pkg::ST_DONE;
            end
          endcase
        end
      end

      bpfa_pkg::ST_SCAN: begin
        if (scan_found) begin
          mem_we     = 1'b1;
          mem_wdata  = mem_rdata | (WORD_W'(1) << scan_pos);
          used_d     = used_q + bpfa_pkg::CNT_W'(1);
          res_addr_d = {hit_frame[bpfa_pkg::FRAME_W-1:0], {bpfa_pkg::FRAME_SHIFT{1'b0}}};
          res_stat_d = bpfa_pkg::STAT_DONE;
          state_d    = bpfa_pkg::ST_DONE;
        end else if (base_next >= {1'b0, lim}) begin
          res_stat_d = bpfa_pkg::STAT_NONE_FREE;
          state_d    = bpfa_pkg::ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = wa_q + AW'(1);
          wa_d      = wa_q + AW'(1);
          base_d    = base_next[bpfa_pkg::CNT_W-1:0];
        end
      end

      bpfa_pkg::ST_DIV: begin
        if (bpfa_pkg::CNT_W'(frame_q) >= lim) begin
          res_stat_d = bpfa_pkg::STAT_RANGE;
          state_d    = bpfa_pkg::ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = div_q;
          wa_d      = div_q;
          state_d   = bpfa_pkg::ST_RMW;
        end
      end

      bpfa_pkg::ST_RMW: begin
        if (mem_rdata[rem] == want) begin
          res_stat_d = bpfa_pkg::STAT_UNCHANGED;
        end else begin
          mem_we         = 1'b1;
          mem_wdata[rem] = want;
          used_d         = want ? (used_q + bpfa_pkg::CNT_W'(1))
                                : (used_q - bpfa_pkg::CNT_W'(1));
          res_stat_d     = bpfa_pkg::STAT_DONE;
        end
        state_d = bpfa_pkg::ST_DONE;
      end

      bpfa_pkg::ST_DONE: begin
        // hand the result to the output register once it has room
        if (out_free_slot) begin
          out_load = 1'b1;
          state_d  = bpfa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bpfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpfa_pkg::ST_CLEAR;
      clr_q   <= '0;
      used_q  <= bpfa_pkg::CNT_W'(1);
      total_q <= bpfa_pkg::CNT_W'(bpfa_pkg::ADDR_FRAMES);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    wa_q       <= wa_d;
    base_q     <= base_d;
    act_q      <= act_d;
    frame_q    <= frame_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
  end

  // output register: holds a finished result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_addr_q <= res_addr_q;
      out_stat_q <= res_stat_q;
      out_free_q <= free_cnt;
      out_used_q <= used_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_stat_q;
  assign free_pages_o     = out_free_q;
  assign used_pages_o     = out_used_q;

endmodule

/* sv/bpfa_checker.sv */
// bpfa_checker: port-level checks of the allocator, bound to the top level
// depends on bpfa_pkg for widths and status codes
module bpfa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]   result_address_o,
  input  logic [1:0]                    status_o,
  input  logic [bpfa_pkg::CNT_W-1:0]    free_pages_o,
  input  logic [bpfa_pkg::CNT_W-1:0]    used_pages_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_address_o)
      && $stable(status_o) && $stable(used_pages_o))
    else $error("stalled result changed");

  // only a successful allocate carries an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != bpfa_pkg::STAT_DONE) |-> result_address_o == '0)
    else $error("address on a result that allocated nothing");

  // a full bitmap leaves no free frames to report
  a_none_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == bpfa_pkg::STAT_NONE_FREE) |-> free_pages_o == '0)
    else $error("none free with free frames counted");

  // result addresses are frame aligned and the used count stays within the address space
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_address_o[bpfa_pkg::FRAME_SHIFT-1:0] == '0)
      && (used_pages_o <= bpfa_pkg::CNT_W'(bpfa_pkg::ADDR_FRAMES)))
    else $error("misaligned address or used count too large");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (.*);
